// ----- hw/rtl/rc4sc_pkg.sv -----
`timescale 1ns / 1ps
package rc4sc_pkg;

   // Permutation table geometry
   localparam int TABLE_DEPTH = 256;
   localparam int BYTE_W      = 8;
   localparam logic [BYTE_W-1:0] LAST_INDEX = 8'hff;

   // Request operation codes
   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_DATA = 1'b1;

   // Sequencer states, one-hot
   typedef enum logic [10:0] {
      ST_IDLE    = 11'b000_0000_0001,
      ST_KS_INIT = 11'b000_0000_0010,
      ST_KS_RD_K = 11'b000_0000_0100,
      ST_KS_RD_A = 11'b000_0000_1000,
      ST_KS_WR_K = 11'b000_0001_0000,
      ST_KS_WR_A = 11'b000_0010_0000,
      ST_DG_RD_I = 11'b000_0100_0000,
      ST_DG_RD_J = 11'b000_1000_0000,
      ST_DG_WR_I = 11'b001_0000_0000,
      ST_DG_WR_J = 11'b010_0000_0000,
      ST_DG_OUT  = 11'b100_0000_0000
   } state_type;

endpackage

// ----- hw/rtl/rc4sc_ram.sv -----
`timescale 1ns / 1ps
module rc4sc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write one entry, read one entry; read returns the old content
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ----- hw/rtl/rc4_stream_cipher_core.sv -----
`timescale 1ns / 1ps
// RC4 cipher core. A key beat appends its byte to the key store (bytes past
// MAX_KEY_BYTES are dropped); the key beat flagged last then runs the key schedule, an
// identity fill followed by one swap step per table entry, during which no beat is taken.
// A data beat's steps are set by the single write port and registered read of the
// permutation table RAM: read S[i], read S[j], write S[i], write S[j] while reading
// S[S[i]+S[j]]. The result register lets the next beat in while the last result waits.
// After reset the table reads as all zeros until the first key schedule, so the keystream
// is zero until then.
module rc4_stream_cipher_core
   import rc4sc_pkg::*;
#(
   parameter int MAX_KEY_BYTES = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_operation,
   input  logic [7:0] req_data_byte,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte
);

   localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam int CW = $clog2(MAX_KEY_BYTES + 1);
   localparam logic [CW-1:0] KEY_CAP = CW'(MAX_KEY_BYTES);

   state_type           state_ff, state_in;
   logic [BYTE_W-1:0]   i_ff, i_in;
   logic [BYTE_W-1:0]   j_ff, j_in;
   logic [BYTE_W-1:0]   k_ff, k_in;
   logic [BYTE_W-1:0]   acc_ff, acc_in;
   logic [BYTE_W-1:0]   held_ff, held_in;
   logic [BYTE_W-1:0]   sj_ff, sj_in;
   logic [BYTE_W-1:0]   sum_ff, sum_in;
   logic                fwd_ff, fwd_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [KW-1:0]       pos_ff, pos_in;
   logic                zeroed_ff, zeroed_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_byte_ff, rsp_byte_in;

   logic                tbl_wr_en;
   logic [BYTE_W-1:0]   tbl_wr_addr, tbl_wr_data, tbl_rd_addr, tbl_rd_raw, tbl_rd;
   logic                key_wr_en;
   logic [KW-1:0]       key_wr_addr;
   logic [BYTE_W-1:0]   key_rd, kb;
   logic                req_fire, rsp_free;
   logic [BYTE_W-1:0]   j_next, acc_next, sum_next;
   logic [CW-1:0]       pos_plus;

   rc4sc_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_raw)
   );

   rc4sc_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_KEY_BYTES)) u_key (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (req_data_byte),
      .rd_addr (pos_ff),
      .rd_data (key_rd)
   );

   assign req_ready    = (state_ff == ST_IDLE);
   assign req_fire     = req_valid && req_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_free     = !rsp_valid_ff || rsp_ready;

   // Table reads as zero until the first identity fill completes
   assign tbl_rd = zeroed_ff ? '0 : tbl_rd_raw;

   // Store key bytes while there is room
   assign key_wr_en   = req_fire && (req_operation == OP_KEY) && (count_ff < KEY_CAP);
   assign key_wr_addr = count_ff[KW-1:0];

   assign kb       = (count_ff == '0) ? '0 : key_rd;
   assign j_next   = j_ff + tbl_rd;
   assign acc_next = kb + tbl_rd + acc_ff;
   assign sum_next = sj_ff + held_ff;
   assign pos_plus = CW'(pos_ff) + CW'(1);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      held_in      = held_ff;
      sj_in        = sj_ff;
      sum_in       = sum_ff;
      fwd_in       = fwd_ff;
      byte_in      = byte_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      zeroed_in    = zeroed_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      tbl_wr_en    = 1'b0;
      tbl_wr_addr  = '0;
      tbl_wr_data  = '0;
      tbl_rd_addr  = '0;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_operation == OP_DATA) begin
                  i_in     = i_ff + 8'd1;
                  byte_in  = req_data_byte;
                  state_in = ST_DG_RD_I;
               end else begin
                  if (count_ff < KEY_CAP) begin
                     count_in = count_ff + CW'(1);
                  end
                  if (req_is_last) begin
                     k_in     = '0;
                     state_in = ST_KS_INIT;
                  end
               end
            end
         end
         ST_KS_INIT: begin
            // Fill the identity permutation
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = k_ff;
            tbl_wr_data = k_ff;
            k_in        = k_ff + 8'd1;
            if (k_ff == LAST_INDEX) begin
               zeroed_in = 1'b0;
               acc_in    = '0;
               pos_in    = '0;
               state_in  = ST_KS_RD_K;
            end
         end
         ST_KS_RD_K: begin
            tbl_rd_addr = k_ff;
            state_in    = ST_KS_RD_A;
         end
         ST_KS_RD_A: begin
            held_in     = tbl_rd;
            acc_in      = acc_next;
            tbl_rd_addr = acc_next;
            pos_in      = (pos_plus >= count_ff) ? '0 : pos_plus[KW-1:0];
            state_in    = ST_KS_WR_K;
         end
         ST_KS_WR_K: begin
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = k_ff;
            tbl_wr_data = tbl_rd;
            state_in    = ST_KS_WR_A;
         end
         ST_KS_WR_A: begin
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = acc_ff;
            tbl_wr_data = held_ff;
            k_in        = k_ff + 8'd1;
            if (k_ff == LAST_INDEX) begin
               i_in     = '0;
               j_in     = '0;
               count_in = '0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_KS_RD_K;
            end
         end
         ST_DG_RD_I: begin
            tbl_rd_addr = i_ff;
            state_in    = ST_DG_RD_J;
         end
         ST_DG_RD_J: begin
            held_in     = tbl_rd;
            j_in        = j_next;
            tbl_rd_addr = j_next;
            state_in    = ST_DG_WR_I;
         end
         ST_DG_WR_I: begin
            sj_in       = tbl_rd;
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = i_ff;
            tbl_wr_data = tbl_rd;
            state_in    = ST_DG_WR_J;
         end
         ST_DG_WR_J: begin
            // Read S[sum] alongside the write of S[j]; forward held on a hit
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = j_ff;
            tbl_wr_data = held_ff;
            tbl_rd_addr = sum_next;
            sum_in      = sum_next;
            fwd_in      = (sum_next == j_ff);
            state_in    = ST_DG_OUT;
         end
         ST_DG_OUT: begin
            // Hold the read address until the result register frees up
            tbl_rd_addr = sum_ff;
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = byte_ff ^ (fwd_ff ? held_ff : tbl_rd);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         count_ff     <= '0;
         zeroed_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         count_ff     <= count_in;
         zeroed_ff    <= zeroed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working payload
   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      acc_ff      <= acc_in;
      held_ff     <= held_in;
      sj_ff       <= sj_in;
      sum_ff      <= sum_in;
      fwd_ff      <= fwd_in;
      byte_ff     <= byte_in;
      pos_ff      <= pos_in;
      rsp_byte_ff <= rsp_byte_in;
   end

endmodule
